@@ hw/rtl/sha1h_pkg.sv @@
// Shared types, constants and round helpers for the SHA-1 message hasher.
`default_nettype none

package sha1h_pkg;

   typedef logic [31:0] word_type;
   // Five 32-bit words; index 0 is H0 (or working variable a).
   typedef logic [4:0][31:0] chain_type;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned RoundBits = $clog2(ROUNDS);

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam word_type MARKER_WORD = {PAD_MARKER, 24'h000000};

   localparam word_type K_0 = 32'h5a827999;
   localparam word_type K_1 = 32'h6ed9eba1;
   localparam word_type K_2 = 32'h8f1bbcdc;
   localparam word_type K_3 = 32'hca62c1d6;

   localparam chain_type INIT_CHAIN = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   // Control to the message schedule window.
   typedef struct packed {
      logic     shift;   // move the window by one word
      logic     expand;  // new word from the schedule recurrence
      word_type word;    // new word when not expanding
   } sched_ctl_type;

   // Control to the working-variable unit.
   typedef struct packed {
      logic load;  // take the chaining words
      logic step;  // run one compression round
   } core_ctl_type;

   // Round function plus round constant.
   function automatic word_type round_mix(logic [RoundBits-1:0] rc, word_type b,
                                          word_type c, word_type d);
      word_type f;
      word_type k;
      if (rc < RoundBits'(20)) begin
         f = (b & c) | (~b & d);
         k = K_0;
      end else if (rc < RoundBits'(40)) begin
         f = b ^ c ^ d;
         k = K_1;
      end else if (rc < RoundBits'(60)) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_2;
      end else begin
         f = b ^ c ^ d;
         k = K_3;
      end
      return f + k;
   endfunction

   // Final message word: keep the leading bytes, then the marker byte; a full word passes unchanged.
   function automatic word_type pad_last(word_type data, logic [2:0] cnt);
      word_type w;
      unique case (cnt)
         3'd0:    w = {PAD_MARKER, 24'h000000};
         3'd1:    w = {data[31:24], PAD_MARKER, 16'h0000};
         3'd2:    w = {data[31:16], PAD_MARKER, 8'h00};
         3'd3:    w = {data[31:8], PAD_MARKER};
         default: w = data;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha1h_sched.sv @@
// Sixteen-word message schedule window with fixed recurrence taps.
`default_nettype none

module sha1h_sched (
   input  wire logic                    clock,
   input  wire sha1h_pkg::sched_ctl_type ctl,
   output sha1h_pkg::word_type          w_out
);

   // win_ff[0] is the oldest word, the one the current round uses
   sha1h_pkg::word_type win_ff [16];
   sha1h_pkg::word_type win_in [16];
   sha1h_pkg::word_type mix;
   sha1h_pkg::word_type fresh;

   // w[t+16] = rol1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
   always_comb begin
      mix   = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      fresh = ctl.expand ? {mix[30:0], mix[31]} : ctl.word;
      for (int i = 0; i < 15; i++) begin
         win_in[i] = ctl.shift ? win_ff[i+1] : win_ff[i];
      end
      win_in[15] = ctl.shift ? fresh : win_ff[15];
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign w_out = win_ff[0];

endmodule

`default_nettype wire

@@ hw/rtl/sha1h_core.sv @@
// Working variables a..e and the shared SHA-1 round unit.
`default_nettype none

module sha1h_core (
   input  wire logic                              clock,
   input  wire sha1h_pkg::core_ctl_type           ctl,
   input  wire logic [sha1h_pkg::RoundBits-1:0]   round_idx,
   input  wire sha1h_pkg::word_type               w_in,
   input  wire sha1h_pkg::chain_type              chain,
   output sha1h_pkg::chain_type                   vars_out
);

   sha1h_pkg::chain_type vars_ff;
   sha1h_pkg::chain_type vars_in;
   sha1h_pkg::word_type  tmp;

   // One round: tmp = rol5(a) + f(b,c,d) + k + e + w
   always_comb begin
      tmp = {vars_ff[0][26:0], vars_ff[0][31:27]}
            + sha1h_pkg::round_mix(round_idx, vars_ff[1], vars_ff[2], vars_ff[3])
            + vars_ff[4] + w_in;
      vars_in = vars_ff;
      if (ctl.load) begin
         vars_in = chain;
      end else if (ctl.step) begin
         vars_in[0] = tmp;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
   end

   assign vars_out = vars_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sha1_message_hash.sv @@
// Top level of the SHA-1 message hasher: sequencer, chaining words, length.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | data_word, byte_count, last_word
//   rsp     | out       | rsp_valid/stall    | digest_word, word_index, digest_end
//
// Every 16th message word starts a block: 80 rounds on the shared round unit,
// then the chaining add.
// A last word is followed by the padding words and the final block(s), then
// five digest items, one per cycle unless rsp_stall holds them.
// Reset (synchronous) loads the initial chaining words and clears the length.
// req_stall is high whenever the block is not waiting for a word.
`default_nettype none

module sha1_message_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_digest_end
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PAD   = 5'b00010,
      S_ROUND = 5'b00100,
      S_ADD   = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      PH_MARK  = 4'b0001,
      PH_ZERO  = 4'b0010,
      PH_LENLO = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   sha1h_pkg::chain_type chain_ff, chain_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [3:0]  pos_ff, pos_in;
   logic [sha1h_pkg::RoundBits-1:0] round_ff, round_in;
   logic        pad_ff, pad_in;
   logic [2:0]  idx_ff, idx_in;

   logic        push;
   sha1h_pkg::word_type push_word;
   logic [2:0]  cnt;
   sha1h_pkg::sched_ctl_type sched_ctl;
   sha1h_pkg::core_ctl_type  core_ctl;
   sha1h_pkg::word_type      w_cur;
   sha1h_pkg::chain_type     vars;

   assign cnt = req_byte_count[2] ? 3'd4 : req_byte_count;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      chain_in  = chain_ff;
      bitlen_in = bitlen_ff;
      round_in  = round_ff;
      pad_in    = pad_ff;
      idx_in    = idx_ff;
      push      = 1'b0;
      push_word = '0;
      core_ctl  = '0;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_OUT);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               push = 1'b1;
               if (!req_last_word) begin
                  push_word = req_data_word;
                  bitlen_in = bitlen_ff + 64'd32;
               end else begin
                  push_word = sha1h_pkg::pad_last(req_data_word, cnt);
                  bitlen_in = bitlen_ff + {58'd0, cnt, 3'b000};
                  pad_in    = 1'b1;
                  phase_in  = (cnt == 3'd4) ? PH_MARK : PH_ZERO;
               end
               if (pos_ff == 4'd15) begin
                  state_in = S_ROUND;
               end else if (req_last_word) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            unique case (phase_ff)
               PH_MARK: begin
                  push_word = sha1h_pkg::MARKER_WORD;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (pos_ff == 4'd14) begin
                     push_word = bitlen_ff[63:32];
                     phase_in  = PH_LENLO;
                  end
               end
               PH_LENLO: begin
                  push_word = bitlen_ff[31:0];
                  phase_in  = PH_DONE;
               end
               default: begin
                  push = 1'b0;
               end
            endcase
            if (pos_ff == 4'd15) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            core_ctl.step = 1'b1;
            round_in = round_ff + 1'b1;
            if (round_ff == sha1h_pkg::RoundBits'(sha1h_pkg::ROUNDS - 1)) begin
               round_in = '0;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + vars[i];
            end
            if (!pad_ff) begin
               state_in = S_IDLE;
            end else if (phase_ff == PH_DONE) begin
               state_in = S_OUT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  idx_in    = '0;
                  chain_in  = sha1h_pkg::INIT_CHAIN;
                  bitlen_in = '0;
                  pad_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      pos_in        = push ? pos_ff + 4'd1 : pos_ff;
      core_ctl.load = push && (pos_ff == 4'd15);
      sched_ctl.shift  = push || (state_ff == S_ROUND);
      sched_ctl.expand = (state_ff == S_ROUND);
      sched_ctl.word   = push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_MARK;
         chain_ff  <= sha1h_pkg::INIT_CHAIN;
         bitlen_ff <= '0;
         pos_ff    <= '0;
         round_ff  <= '0;
         pad_ff    <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         chain_ff  <= chain_in;
         bitlen_ff <= bitlen_in;
         pos_ff    <= pos_in;
         round_ff  <= round_in;
         pad_ff    <= pad_in;
         idx_ff    <= idx_in;
      end
   end

   sha1h_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .w_out (w_cur)
   );

   sha1h_core u_core (
      .clock     (clock),
      .ctl       (core_ctl),
      .round_idx (round_ff),
      .w_in      (w_cur),
      .chain     (chain_ff),
      .vars_out  (vars)
   );

   // Digest item output straight from the chaining words
   always_comb begin
      rsp_digest_word = chain_ff[0];
      unique case (idx_ff)
         3'd0:    rsp_digest_word = chain_ff[0];
         3'd1:    rsp_digest_word = chain_ff[1];
         3'd2:    rsp_digest_word = chain_ff[2];
         3'd3:    rsp_digest_word = chain_ff[3];
         default: rsp_digest_word = chain_ff[4];
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_digest_end = (idx_ff == 3'd4);

endmodule

`default_nettype wire

@@ test/sha1_digest_checker.sv @@
// Digest checker for the SHA-1 hasher: predicts each digest and compares it.
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_digest_end,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [159:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };
   localparam logic [31:0] K_ROUND_0 = 32'h5a827999;
   localparam logic [31:0] K_ROUND_1 = 32'h6ed9eba1;
   localparam logic [31:0] K_ROUND_2 = 32'h8f1bbcdc;
   localparam logic [31:0] K_ROUND_3 = 32'hca62c1d6;
   localparam logic [31:0] PAD_WORD  = 32'h80000000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   // predictor state
   logic [31:0]  hash_state [5];
   logic [31:0]  block_words [16];
   logic [63:0]  msg_bits;
   logic [3:0]   fill_pos;

   digest_item_type digest_q [$];
   digest_item_type want;
   int           fail_total = 0;
   int           queued = 0;

   assign failures = fail_total;
   assign pending  = queued;

   // back to the start of a fresh message
   task automatic restart_message();
      int i;
      for (i = 0; i < 5; i++) hash_state[i] = H_INIT[32*i +: 32];
      msg_bits = '0;
      fill_pos = '0;
   endtask

   // 80 rounds over the buffered block, folded into the hash state
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, t;
      int r;
      for (r = 0; r < 16; r++) w[r] = block_words[r];
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (r = 0; r < 80; r++) begin
         if (r < 16) begin
            x = w[r];
         end else begin
            x = w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16];
            x = {x[30:0], x[31]};
            w[r % 16] = x;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND_0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND_1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND_2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND_3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + x;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_state[0] = hash_state[0] + a;
      hash_state[1] = hash_state[1] + b;
      hash_state[2] = hash_state[2] + c;
      hash_state[3] = hash_state[3] + d;
      hash_state[4] = hash_state[4] + e;
   endtask

   // one word into the block buffer; a full buffer is compressed
   task automatic absorb_word(input logic [31:0] word);
      block_words[fill_pos] = word;
      fill_pos = fill_pos + 4'd1;
      if (fill_pos == 4'd0) compress_block();
   endtask

   // accepted input item; a last word pads, finishes and queues the digest
   task automatic take_item(input logic [31:0] data, input logic [2:0] cnt,
                            input logic last);
      logic [2:0]   n;
      logic [31:0]  mask;
      digest_item_type item;
      int i;
      n = (cnt > 3'd4) ? 3'd4 : cnt;
      if (!last) begin
         msg_bits = msg_bits + 64'd32;
         absorb_word(data);
      end else begin
         msg_bits = msg_bits + 64'(n) * 64'd8;
         if (n == 3'd4) begin
            absorb_word(data);
            absorb_word(PAD_WORD);
         end else begin
            mask = ~(32'hffffffff >> (8 * n));
            absorb_word((data & mask) | (32'h80 << (24 - 8 * n)));
         end
         while (fill_pos != 4'd14) absorb_word(32'h0);
         absorb_word(msg_bits[63:32]);
         absorb_word(msg_bits[31:0]);
         for (i = 0; i < 5; i++) begin
            item.word  = hash_state[i];
            item.index = 3'(i);
            item.last  = (i == 4);
            digest_q.push_back(item);
         end
         restart_message();
      end
   endtask

   // watch both channels: results first, they belong to older items
   always @(posedge clock) begin
      if (reset) begin
         restart_message();
         for (int j = 0; j < 16; j++) block_words[j] = '0;
         digest_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $error("digest item with none expected: word %h index %0d end %0b",
                      rsp_digest_word, rsp_word_index, rsp_digest_end);
               fail_total++;
            end else begin
               want = digest_q.pop_front();
               if (rsp_digest_word !== want.word) begin
                  $error("digest_word: expected %h, actual %h", want.word,
                         rsp_digest_word);
                  fail_total++;
               end
               if (rsp_word_index !== want.index) begin
                  $error("word_index: expected %0d, actual %0d", want.index,
                         rsp_word_index);
                  fail_total++;
               end
               if (rsp_digest_end !== want.last) begin
                  $error("digest_end: expected %0b, actual %0b", want.last,
                         rsp_digest_end);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            take_item(req_data_word, req_byte_count, req_last_word);
      end
      queued <= digest_q.size();
   end

endmodule

@@ test/tb_sha1_message_hash.sv @@
// Top of the SHA-1 hasher testbench: clock, reset, message stimulus and verdict.
module tb_sha1_message_hash;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 700;
   localparam int DRAIN_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_end;

   int mismatches;
   int outstanding;
   int send_pct = 0;
   int recv_pct = 0;
   int words_sent = 0;
   int cycle_count = 0;
   bit hold_req = 1'b0;
   bit hold_served = 1'b0;

   sha1_message_hash i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_end  (rsp_digest_end)
   );

   sha1_digest_checker i_digest_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_end  (rsp_digest_end),
      .failures        (mismatches),
      .pending         (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // digest receiver: random stalls, plus one long hold-off when asked
   always begin
      @(posedge clock);
      if (hold_req && !hold_served) begin
         hold_served = 1'b1;
         repeat (HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // offer one item after random idle cycles, return once it is taken
   task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                            input logic last);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_byte_count <= cnt;
      req_last_word  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // body words carry random counts, which the block ignores
   task automatic send_message(input int body_words, input logic [2:0] last_cnt);
      for (int i = 0; i < body_words; i++)
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send_word($urandom, last_cnt, 1'b1);
   endtask

   // sender goes quiet until every digest word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // random messages, mostly short, some spanning several blocks
   task automatic random_phase(input int n_items, input int s_pct, input int r_pct,
                               input bit with_hold);
      int goal;
      int body;
      send_pct = s_pct;
      recv_pct = r_pct;
      goal = words_sent + n_items;
      if (with_hold) hold_req = 1'b1;
      while (words_sent < goal) begin
         body = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40)
                                            : $urandom_range(0, 6);
         send_message(body, 3'($urandom_range(0, 7)));
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pct = 11;
      recv_pct = 57;

      // empty message, partial and full last words at the data extremes
      send_word(32'hffffffff, 3'd0, 1'b1);
      send_word(32'hffffffff, 3'd1, 1'b1);
      send_word(32'h00000000, 3'd2, 1'b1);
      send_word(32'hffffffff, 3'd3, 1'b1);
      send_word(32'h00000000, 3'd4, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      // counts above four act as four
      send_word($urandom, 3'd5, 1'b1);
      send_word($urandom, 3'd6, 1'b1);
      send_word($urandom, 3'd7, 1'b1);
      // short body word that is not last counts as full
      send_word($urandom, 3'd1, 1'b0);
      send_word($urandom, 3'd0, 1'b1);
      // padded word lands in slot 14: length spills into an extra block
      send_message(14, 3'd2);
      wait_drained();

      random_phase(70, 11, 57, 1'b0);
      random_phase(70, 57, 11, 1'b0);
      random_phase(75, 0, 0, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sha1_message_hash.f @@
hw/rtl/sha1h_pkg.sv
hw/rtl/sha1h_sched.sv
hw/rtl/sha1h_core.sv
hw/rtl/sha1_message_hash.sv
test/sha1_digest_checker.sv
test/tb_sha1_message_hash.sv
